// ----- hdl/assert_macros.svh -----
// Assertion macros for the base64 codec RTL (used by b64_obuf).
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMPLY(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/b64_pkg.sv -----
// Shared types, codes and character mapping functions for the base64 codec.
// No dependencies.
`timescale 1ns / 1ps
package b64_pkg;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            last;
    logic            bad;
  } res_t;

  function automatic logic [7:0] alpha_of(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26)      alpha_of = w + 8'h41;
      else if (v < 6'd52) alpha_of = w + 8'h47;
      else if (v < 6'd62) alpha_of = w - 8'h04;
      else if (v == 6'd62) alpha_of = CHAR_PLUS;
      else                alpha_of = CHAR_SLASH;
    end
  endfunction

  // bit 6 set: not an alphabet character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      if (c >= 8'h41 && c <= 8'h5A)      d = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) d = c - 8'h47;
      else if (c >= 8'h30 && c <= 8'h39) d = c + 8'h04;
      else if (c == CHAR_PLUS)           d = 8'd62;
      else if (c == CHAR_SLASH)          d = 8'd63;
      else                               d = 8'd64;
      sextet_of = d[6:0];
    end
  endfunction

endpackage

// ----- hdl/b64_xlat.sv -----
// Group state and per-item translation for the base64 codec.
// Depends on b64_pkg.
`timescale 1ns / 1ps
module b64_xlat (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          mode,
  input  logic          clr,
  input  logic          step,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output b64_pkg::res_t res,
  output logic          has_res
);
  import b64_pkg::*;

  logic [23:0] grp_bits_r, grp_bits_nxt;
  logic [1:0]  grp_fill_r, grp_fill_nxt;
  logic        third_pad_r, third_pad_nxt;
  logic        saw_bad_r, saw_bad_nxt;

  logic [2:0]  fill;
  logic [23:0] enc_shift;
  logic [23:0] triple;
  logic [1:0]  pads;
  logic [23:0] dec_shift;
  logic [6:0]  sx;
  logic        is_pad;
  logic        bad_now;
  logic [1:0]  drop;

  always_comb begin
    fill          = {1'b0, grp_fill_r} + 3'd1;
    enc_shift     = {grp_bits_r[15:0], in_byte};
    is_pad        = (in_byte == PAD_CHAR);
    sx            = sextet_of(in_byte);
    bad_now       = !is_pad && sx[6];
    dec_shift     = {grp_bits_r[17:0], (is_pad || sx[6]) ? 6'd0 : sx[5:0]};
    triple        = enc_shift;
    pads          = 2'd0;
    drop          = 2'd0;
    grp_bits_nxt  = grp_bits_r;
    grp_fill_nxt  = grp_fill_r;
    third_pad_nxt = third_pad_r;
    saw_bad_nxt   = saw_bad_r;
    res           = '0;

    if (mode == MODE_ENC) begin
      if (fill < 3'd3 && !in_last) begin
        grp_bits_nxt = enc_shift;
        grp_fill_nxt = fill[1:0];
      end else begin
        case (fill)
          3'd1: begin
            triple = {enc_shift[7:0], 16'h0000};
            pads   = 2'd2;
          end
          3'd2: begin
            triple = {enc_shift[15:0], 8'h00};
            pads   = 2'd1;
          end
          default: begin
            triple = enc_shift;
            pads   = 2'd0;
          end
        endcase
        res.data[0] = alpha_of(triple[23:18]);
        res.data[1] = alpha_of(triple[17:12]);
        res.data[2] = (pads == 2'd2) ? PAD_CHAR : alpha_of(triple[11:6]);
        res.data[3] = (pads != 2'd0) ? PAD_CHAR : alpha_of(triple[5:0]);
        res.cnt     = 3'd4;
        res.last    = in_last;
        res.bad     = 1'b0;
        grp_bits_nxt = '0;
        grp_fill_nxt = '0;
      end
    end else begin
      saw_bad_nxt = saw_bad_r | bad_now;
      if (fill == 3'd3) third_pad_nxt = is_pad;
      if (fill < 3'd4) begin
        grp_bits_nxt = dec_shift;
        grp_fill_nxt = fill[1:0];
        if (in_last) begin
          res.cnt  = 3'd1;
          res.last = 1'b1;
          res.bad  = 1'b1;
        end
      end else begin
        drop = {1'b0, in_last & is_pad} + {1'b0, in_last & third_pad_r};
        res.data[0] = dec_shift[23:16];
        res.data[1] = dec_shift[15:8];
        res.data[2] = dec_shift[7:0];
        res.cnt     = 3'd3 - {1'b0, drop};
        res.last    = in_last;
        res.bad     = saw_bad_nxt;
        grp_bits_nxt  = '0;
        grp_fill_nxt  = '0;
        third_pad_nxt = 1'b0;
      end
    end

    if (in_last) begin
      grp_bits_nxt  = '0;
      grp_fill_nxt  = '0;
      third_pad_nxt = 1'b0;
      saw_bad_nxt   = 1'b0;
    end
  end

  assign has_res = (res.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      grp_bits_r  <= '0;
      grp_fill_r  <= '0;
      third_pad_r <= 1'b0;
      saw_bad_r   <= 1'b0;
    end else if (step) begin
      grp_bits_r  <= grp_bits_nxt;
      grp_fill_r  <= grp_fill_nxt;
      third_pad_r <= third_pad_nxt;
      saw_bad_r   <= saw_bad_nxt;
    end
  end

endmodule

// ----- hdl/b64_obuf.sv -----
// Result register and serializer for the base64 codec, one result per cycle while out_ready is high.
// Depends on b64_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  b64_pkg::res_t res,
  output logic          can_load,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_run_end,
  output logic          out_message_end,
  output logic          out_bad_input
);
  import b64_pkg::*;

  res_t       grp_r;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       final_beat;
  logic       xfer;

  assign final_beat      = ({1'b0, idx_r} == grp_r.cnt - 3'd1);
  assign xfer            = busy_r && out_ready;
  assign can_load        = !busy_r || (final_beat && out_ready);
  assign out_valid       = busy_r;
  assign out_byte        = grp_r.data[idx_r];
  assign out_run_end     = final_beat;
  assign out_message_end = final_beat && grp_r.last;
  assign out_bad_input   = grp_r.bad;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end else if (xfer) begin
      if (final_beat) begin
        busy_nxt = 1'b0;
        idx_nxt  = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) grp_r <= res;
  end

  `AST_IMPLY(a_cnt_range, busy_r, grp_r.cnt != 3'd0 && grp_r.cnt <= 3'd4)
  `AST_NEXT(a_more_beats, xfer && !final_beat, busy_r && idx_r == $past(idx_r) + 2'd1)
  `AST_NEXT(a_hold_beat, busy_r && !out_ready, busy_r && $stable(idx_r))
  `AST_IMPLY(a_load_when_free, load, can_load)

endmodule

// ----- hdl/base64_stream_codec.sv -----
// Base64 stream codec top level: input register, mode register and submodules.
// Depends on b64_pkg, b64_xlat and b64_obuf.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready carries in_byte and in_last, one byte or
//   character per transfer; in_last marks the final one of a message.
//   Output channel out_valid/out_ready carries one result per transfer:
//   out_byte, out_run_end (last result of that input), out_message_end and
//   out_bad_input.
//   cfg_wr_en/cfg_wr_data write the mode (0 encode, 1 decode) and clear all
//   group state; write only while the block is idle.
// Order: an input transfer is captured in the input register, translated
//   combinationally and loaded into the result register, which drives
//   out_valid; an input that produces no result retires without a load.
// Throughput: one input per cycle while no results are pending; the output
//   side emits one result per cycle while out_ready is high; a group (four
//   results per up to three bytes when encoding) holds the result register.
// Reset: synchronous, clears the mode to encode and all group state.
// Stall: while out_ready is low the current result holds; the input register
//   keeps one more item and in_ready drops until the result register frees.
module base64_stream_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_message_end,
  output logic       out_bad_input,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import b64_pkg::*;

  logic       mode_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  res_t       res;
  logic       has_res;
  logic       can_load;
  logic       step;

  assign step     = s1_valid_r && (can_load || !has_res);
  assign in_ready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ENC;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (in_valid && in_ready) s1_valid_r <= 1'b1;
      else if (step)            s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  b64_xlat u_xlat (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode_r),
    .clr     (cfg_wr_en),
    .step    (step),
    .in_byte (s1_byte_r),
    .in_last (s1_last_r),
    .res     (res),
    .has_res (has_res)
  );

  b64_obuf u_obuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (step && has_res),
    .res             (res),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end),
    .out_bad_input   (out_bad_input)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for base64_stream_codec: encode and decode messages,
// mode switches and output backpressure, checked against an in-bench codec.
// Depends on b64_pkg and the base64_stream_codec RTL.
module tb;
  import b64_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLD_CYCLES    = 150;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
    logic       bad;
  } codec_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_end;
  logic       out_message_end;
  logic       out_bad_input;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  // codec state as seen by the bench
  logic        cur_mode;
  logic [23:0] grp_bits;
  int          grp_fill;
  logic        third_pad;
  logic        bad_seen;

  codec_word_t awaited_words[$];
  logic [7:0]  msg_bytes[$];
  codec_word_t got_word;
  codec_word_t want_word;

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  base64_stream_codec u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_message_end(out_message_end),
    .out_bad_input  (out_bad_input),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] b64_char(input int v);
    if (v < 26) begin
      return 8'(v) + 8'h41;
    end else if (v < 52) begin
      return 8'(v - 26) + 8'h61;
    end else if (v < 62) begin
      return 8'(v - 52) + 8'h30;
    end else if (v == 62) begin
      return CHAR_PLUS;
    end
    return CHAR_SLASH;
  endfunction

  // -1 for a character outside the alphabet
  function automatic int b64_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return int'(c) - 'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      return int'(c) - 'h61 + 26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      return int'(c) - 'h30 + 52;
    end else if (c == CHAR_PLUS) begin
      return 62;
    end else if (c == CHAR_SLASH) begin
      return 63;
    end
    return -1;
  endfunction

  task automatic clear_group();
    grp_bits  = '0;
    grp_fill  = 0;
    third_pad = 1'b0;
    bad_seen  = 1'b0;
  endtask

  // Work out the words that one accepted byte produces and queue them.
  task automatic b64_transform(input logic [7:0] b, input logic l);
    logic [7:0]  chs[4];
    logic        bads[4];
    logic [23:0] triple;
    logic        is_pad;
    int          n;
    int          fill;
    int          sx;
    int          pads;
    int          i;
    n = 0;
    fill = grp_fill + 1;
    if (cur_mode == MODE_ENC) begin
      grp_bits = {grp_bits[15:0], b};
      if (fill < 3 && !l) begin
        grp_fill = fill;
      end else begin
        if (fill >= 3) begin
          triple = grp_bits;
          pads = 0;
        end else begin
          triple = grp_bits << (8 * (3 - fill));
          pads = (fill == 1) ? 2 : 1;
        end
        for (i = 0; i < 4; i++) begin
          chs[i] = (i >= 4 - pads) ? PAD_CHAR : b64_char(int'(6'(triple >> (18 - 6 * i))));
          bads[i] = 1'b0;
        end
        n = 4;
        grp_fill = 0;
        grp_bits = '0;
      end
    end else begin
      is_pad = (b == PAD_CHAR);
      sx = is_pad ? 0 : b64_value(b);
      if (sx < 0) begin
        sx = 0;
        bad_seen = 1'b1;
      end
      grp_bits = {grp_bits[17:0], 6'(sx)};
      if (fill == 3) third_pad = is_pad;
      if (fill < 4) begin
        grp_fill = fill;
        if (l) begin
          chs[0] = 8'h00;
          bads[0] = 1'b1;
          n = 1;
        end
      end else begin
        n = 3;
        if (l) begin
          if (is_pad) n--;
          if (third_pad) n--;
        end
        for (i = 0; i < n; i++) begin
          chs[i] = 8'(grp_bits >> (16 - 8 * i));
          bads[i] = bad_seen;
        end
        grp_fill = 0;
        grp_bits = '0;
        third_pad = 1'b0;
      end
    end
    for (i = 0; i < n; i++) begin
      awaited_words.push_back('{chs[i], i == n - 1, l && (i == n - 1), bads[i]});
    end
    if (l) clear_group();
  endtask

  task automatic send_item(input logic [7:0] b, input logic l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (!in_ready);
    b64_transform(b, l);
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg_bytes.size(); i++) begin
      send_item(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = m;
    clear_group();
  endtask

  task automatic test_encode_directed();
    write_mode(MODE_ENC);
    msg_bytes = {8'hFF};
    send_message();
    msg_bytes = {8'h00, 8'hFB};
    send_message();
    msg_bytes = {8'hF8, 8'h00, 8'hFF, 8'h7F};
    send_message();
  endtask

  task automatic test_decode_directed();
    write_mode(MODE_DEC);
    msg_bytes = {"+", "/", "9", "z", "Q", "Q", "=", "="};
    send_message();
    msg_bytes = {"A", "=", "B", "=", "Q", "*", "=", "="};
    send_message();
    msg_bytes = {"Z", "m"};
    send_message();
  endtask

  task automatic test_mode_write_mid_message();
    write_mode(MODE_ENC);
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    write_mode(MODE_ENC);
    msg_bytes = {"M", "a", "n"};
    send_message();
    write_mode(MODE_DEC);
    send_item("Q", 1'b0);
    send_item("U", 1'b0);
    write_mode(MODE_DEC);
    msg_bytes = {"T", "W", "F", "u"};
    send_message();
  endtask

  task automatic test_random_encode(input int n_items);
    int sent;
    int len;
    int i;
    write_mode(MODE_ENC);
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 8);
      msg_bytes = {};
      for (i = 0; i < len; i++) msg_bytes.push_back(8'($urandom_range(255)));
      send_message();
      sent += len;
    end
  endtask

  task automatic test_random_decode(input int n_items);
    int         sent;
    int         kind;
    int         quads;
    int         pads;
    int         i;
    logic [7:0] c;
    write_mode(MODE_DEC);
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      msg_bytes = {};
      if (kind < 8) begin
        for (i = 0; i < $urandom_range(1, 6); i++) msg_bytes.push_back(8'($urandom_range(255)));
      end else begin
        quads = $urandom_range(1, 3);
        for (i = 0; i < 4 * quads; i++) msg_bytes.push_back(b64_char($urandom_range(63)));
        pads = $urandom_range(0, 2);
        for (i = 0; i < pads; i++) msg_bytes[4 * quads - 1 - i] = PAD_CHAR;
        if (kind < 18) begin
          do c = 8'($urandom_range(255)); while (b64_value(c) >= 0 || c == PAD_CHAR);
          msg_bytes[$urandom_range(4 * quads - 1)] = c;
        end else if (kind < 28) begin
          repeat ($urandom_range(1, 3)) void'(msg_bytes.pop_back());
        end else if (kind < 36 && quads > 1) begin
          msg_bytes[$urandom_range(3)] = PAD_CHAR;
        end
      end
      send_message();
      sent += msg_bytes.size();
    end
  endtask

  task automatic test_output_backpressure();
    int saved_idle;
    int saved_stall;
    int i;
    saved_idle = send_idle_pct;
    saved_stall = recv_stall_pct;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_mode(MODE_ENC);
    hold_reqs++;
    repeat (4) begin
      msg_bytes = {};
      for (i = 0; i < 6; i++) msg_bytes.push_back(8'($urandom_range(255)));
      send_message();
    end
    wait_drained();
    send_idle_pct = saved_idle;
    recv_stall_pct = saved_stall;
  endtask

  // check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word = '{out_byte, out_run_end, out_message_end, out_bad_input};
      if (awaited_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: byte %02h run_end %0b message_end %0b bad %0b",
                   got_word.ch, got_word.run_end, got_word.msg_end, got_word.bad);
      end else begin
        want_word = awaited_words.pop_front();
        if (got_word != want_word) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected byte %02h run_end %0b message_end %0b bad %0b",
                     want_word.ch, want_word.run_end, want_word.msg_end, want_word.bad);
            $display("          got byte %02h run_end %0b message_end %0b bad %0b",
                     got_word.ch, got_word.run_end, got_word.msg_end, got_word.bad);
          end
        end
      end
    end
  end

  // decide out_ready for the next cycle, with long holds on request
  always @(posedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    cur_mode = MODE_ENC;
    clear_group();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_encode_directed();
    test_decode_directed();
    test_mode_write_mid_message();
    test_random_encode(10);
    test_random_decode(10);

    send_idle_pct = 66;
    recv_stall_pct = 0;
    test_random_decode(10);
    test_random_encode(8);

    send_idle_pct = 0;
    recv_stall_pct = 66;
    test_random_encode(10);
    test_random_decode(8);

    send_idle_pct = 22;
    recv_stall_pct = 22;
    test_random_decode(10);
    test_random_encode(8);
    test_output_backpressure();

    wait_drained();
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/b64_pkg.sv
hdl/b64_xlat.sv
hdl/b64_obuf.sv
hdl/base64_stream_codec.sv
dv/tb.sv
